// ===== design/cbt_pkg.sv =====
package cbt_pkg;

    localparam int C_COORD_W  = 32;
    localparam int C_N_COORDS = 8;
    localparam int C_DET_W    = 6;
    // weights and t are Q1.16, so 65536 needs the 17th bit
    localparam int C_W_W      = 17;
    localparam int C_PROD_W   = C_COORD_W + C_W_W + 1;
    localparam int C_TERM_W   = C_PROD_W - 16;
    localparam int C_SUM_W    = C_TERM_W + 2;
    localparam int C_DIV_STEPS = C_W_W;

    localparam logic [C_DET_W-1:0] C_DETAIL_RESET = 6'd20;
    localparam logic [C_DET_W-1:0] C_MAX_STEPS    = 6'd63;
    localparam logic [C_W_W-1:0]   C_ONE          = 17'h10000;

    typedef logic signed [C_COORD_W-1:0] t_coord;

    // reciprocal of the segment count: 65536 = quo * div + rem
    typedef struct packed {
        logic                 busy;
        logic [C_W_W-1:0]     quo;
        logic [C_DET_W-1:0]   rem;
        logic [C_DET_W-1:0]   div;
    } t_recip;

    typedef struct packed {
        logic             valid;
        logic             last;
        logic [C_W_W-1:0] t;
    } t_step;

    typedef struct packed {
        logic             valid;
        logic             last;
        logic [C_W_W-1:0] w0;
        logic [C_W_W-1:0] w1;
        logic [C_W_W-1:0] w2;
        logic [C_W_W-1:0] w3;
    } t_wts;

endpackage

// ===== design/cbt_recip.sv =====
module cbt_recip
    import cbt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [C_DET_W-1:0] i_cfg_wdata,
    output t_recip             o_recip
);

    logic                 r_busy;
    logic [4:0]           r_cnt;
    logic [C_DET_W-1:0]   r_rem;
    logic [C_W_W-1:0]     r_quo;
    logic [C_DET_W-1:0]   r_div;

    logic [C_DET_W-1:0]   n_div;
    logic [C_DET_W:0]     n_shift;
    logic                 n_fits;

    always_comb begin
        n_div = (i_cfg_wdata == '0) ? C_DET_W'(1) : i_cfg_wdata;
        if (n_div > C_MAX_STEPS) begin
            n_div = C_MAX_STEPS;
        end
        // dividend is 1 << 16: its only set bit comes first
        n_shift = {r_rem, (r_cnt == 5'd0)};
        n_fits  = n_shift >= {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_rem  <= '0;
            r_quo  <= '0;
            r_div  <= C_DETAIL_RESET;
        end else if (i_cfg_we) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_rem  <= '0;
            r_quo  <= '0;
            r_div  <= n_div;
        end else if (r_busy) begin
            r_rem <= n_fits ? C_DET_W'(n_shift - {1'b0, r_div}) : n_shift[C_DET_W-1:0];
            r_quo <= {r_quo[C_W_W-2:0], n_fits};
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'(C_DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_recip.busy = r_busy;
    assign o_recip.quo  = r_quo;
    assign o_recip.rem  = r_rem;
    assign o_recip.div  = r_div;

endmodule

// ===== design/cbt_seq.sv =====
module cbt_seq
    import cbt_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    input  logic   i_en,
    input  t_recip i_recip,
    output t_step  o_step
);

    logic                 r_active;
    logic [C_DET_W-1:0]   r_idx;
    logic [C_W_W-1:0]     r_t;
    logic [C_DET_W-1:0]   r_rem;

    logic [C_DET_W:0]     n_rsum;
    logic                 n_wrap;
    logic                 n_last;

    always_comb begin
        n_rsum = {1'b0, r_rem} + {1'b0, i_recip.rem};
        n_wrap = n_rsum >= {1'b0, i_recip.div};
        n_last = r_idx == i_recip.div;
    end

    // t advances by 65536/D with the remainder carried, so t = floor(i*65536/D)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_idx    <= '0;
            r_t      <= '0;
            r_rem    <= '0;
        end else if (i_start) begin
            r_active <= 1'b1;
            r_idx    <= '0;
            r_t      <= '0;
            r_rem    <= '0;
        end else if (r_active && i_en) begin
            if (n_last) begin
                r_active <= 1'b0;
            end else begin
                r_idx <= r_idx + C_DET_W'(1);
                r_t   <= r_t + i_recip.quo + C_W_W'(n_wrap);
                r_rem <= n_wrap ? C_DET_W'(n_rsum - {1'b0, i_recip.div})
                                : n_rsum[C_DET_W-1:0];
            end
        end
    end

    assign o_step.valid = r_active;
    assign o_step.last  = n_last;
    assign o_step.t     = r_t;

endmodule

// ===== design/cbt_weights.sv =====
module cbt_weights
    import cbt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_step i_step,
    output t_wts  o_wts,
    output logic  o_busy
);

    logic                 r1_valid, r2_valid, r3_valid;
    logic                 r1_last, r2_last, r3_last;
    logic [C_W_W-1:0]     r1_t, r1_mt, r1_t2, r1_mt2;
    logic [C_W_W-1:0]     r2_mt3, r2_w1r, r2_w2r, r2_t3;
    logic [C_W_W-1:0]     r3_w0, r3_w1, r3_w2, r3_w3;

    logic [C_W_W-1:0]     n_mt;
    logic [2*C_W_W-1:0]   n_mt2p, n_t2p, n_mt3p, n_w1p, n_w2p, n_t3p;
    logic [C_W_W+1:0]     n_w1x3, n_w2x3;

    always_comb begin
        n_mt   = C_ONE - i_step.t;
        n_mt2p = n_mt * n_mt;
        n_t2p  = i_step.t * i_step.t;
        n_mt3p = r1_mt2 * r1_mt;
        n_w1p  = r1_mt2 * r1_t;
        n_w2p  = r1_mt * r1_t2;
        n_t3p  = r1_t2 * r1_t;
        n_w1x3 = {r2_w1r, 1'b0} + {2'b00, r2_w1r};
        n_w2x3 = {r2_w2r, 1'b0} + {2'b00, r2_w2r};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_step.valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_last <= i_step.last;
            r1_t    <= i_step.t;
            r1_mt   <= n_mt;
            r1_mt2  <= n_mt2p[C_W_W+15:16];
            r1_t2   <= n_t2p[C_W_W+15:16];

            r2_last <= r1_last;
            r2_mt3  <= n_mt3p[C_W_W+15:16];
            r2_w1r  <= n_w1p[C_W_W+15:16];
            r2_w2r  <= n_w2p[C_W_W+15:16];
            r2_t3   <= n_t3p[C_W_W+15:16];

            // 3 * w stays below 2^15, the top bits are zero
            r3_last <= r2_last;
            r3_w0   <= r2_mt3;
            r3_w1   <= n_w1x3[C_W_W-1:0];
            r3_w2   <= n_w2x3[C_W_W-1:0];
            r3_w3   <= r2_t3;
        end
    end

    assign o_wts.valid = r3_valid;
    assign o_wts.last  = r3_last;
    assign o_wts.w0    = r3_w0;
    assign o_wts.w1    = r3_w1;
    assign o_wts.w2    = r3_w2;
    assign o_wts.w3    = r3_w3;
    assign o_busy      = r1_valid | r2_valid | r3_valid;

endmodule

// ===== design/cbt_blend.sv =====
module cbt_blend
    import cbt_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  t_wts   i_wts,
    input  t_coord i_coords [C_N_COORDS],
    output t_coord o_x,
    output t_coord o_y,
    output logic   o_last,
    output logic   o_valid,
    output logic   o_busy
);

    logic                       r4_valid, r5_valid, r6_valid;
    logic                       r4_last, r5_last, r6_last;
    logic signed [C_PROD_W-1:0] r4_prod [C_N_COORDS];
    logic signed [C_TERM_W-1:0] r5_term [C_N_COORDS];
    t_coord                     r6_x, r6_y;

    logic [C_W_W-1:0]           n_w [4];
    logic signed [C_PROD_W-1:0] n_prod [C_N_COORDS];
    logic signed [C_TERM_W-1:0] n_term [C_N_COORDS];
    logic signed [C_SUM_W-1:0]  n_sx, n_sy;
    t_coord                     n_x, n_y;

    function automatic t_coord sat(input logic signed [C_SUM_W-1:0] s);
        t_coord r;
        if (s > C_SUM_W'(64'sd2147483647)) begin
            r = 32'sh7FFFFFFF;
        end else if (s < -C_SUM_W'(64'sd2147483648)) begin
            r = 32'sh80000000;
        end else begin
            r = s[C_COORD_W-1:0];
        end
        return r;
    endfunction

    always_comb begin
        n_w[0] = i_wts.w0;
        n_w[1] = i_wts.w1;
        n_w[2] = i_wts.w2;
        n_w[3] = i_wts.w3;
        for (int k = 0; k < C_N_COORDS; k++) begin
            n_prod[k] = $signed(i_coords[k]) * $signed({1'b0, n_w[k/2]});
        end
        // shift right by 16, then step toward zero for negatives with a fraction
        for (int k = 0; k < C_N_COORDS; k++) begin
            n_term[k] = r4_prod[k][C_PROD_W-1:16]
                + C_TERM_W'(r4_prod[k][C_PROD_W-1] && (r4_prod[k][15:0] != '0));
        end
        n_sx = C_SUM_W'(r5_term[0]) + C_SUM_W'(r5_term[2])
             + C_SUM_W'(r5_term[4]) + C_SUM_W'(r5_term[6]);
        n_sy = C_SUM_W'(r5_term[1]) + C_SUM_W'(r5_term[3])
             + C_SUM_W'(r5_term[5]) + C_SUM_W'(r5_term[7]);
        n_x  = sat(n_sx);
        n_y  = sat(n_sy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
        end else if (i_en) begin
            r4_valid <= i_wts.valid;
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_last <= i_wts.last;
            for (int k = 0; k < C_N_COORDS; k++) begin
                r4_prod[k] <= n_prod[k];
            end
            r5_last <= r4_last;
            for (int k = 0; k < C_N_COORDS; k++) begin
                r5_term[k] <= n_term[k];
            end
            r6_last <= r5_last;
            r6_x    <= n_x;
            r6_y    <= n_y;
        end
    end

    assign o_x     = r6_x;
    assign o_y     = r6_y;
    assign o_last  = r6_last;
    assign o_valid = r6_valid;
    assign o_busy  = r4_valid | r5_valid;

endmodule

// ===== design/cubic_bezier_tessellator_core.sv =====
// Channel  Dir  Bits  Contents
// s        in   256   tdata: start_x, start_y, ctrl_a_x, ctrl_a_y,
//                     ctrl_b_x, ctrl_b_y, end_x, end_y (32 each, low first)
// m        out  64    tdata: point_x, point_y; tlast: last_point
// cfg      in   6     detail_steps, taken when i_cfg_we is high
//
// One curve gives D+1 points, one per cycle while m does not stall, through
// a seven-register pipeline (step counter, three weight stages, product,
// truncate, sum and saturate). A new curve is taken once the pipeline ahead
// of the output register drains. After reset and after each detail write a
// serial divider forms 65536/D; no curve is taken meanwhile. Reset is
// synchronous, active low. A stall on m holds every stage in place.
module cubic_bezier_tessellator_core
    import cbt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    // start_x, start_y, ctrl_a_x, ctrl_a_y, ctrl_b_x, ctrl_b_y, end_x, end_y
    input  logic [255:0]       i_s_tdata,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    // point_x, point_y
    output logic [63:0]        o_m_tdata,
    output logic               o_m_tlast,
    input  logic               i_cfg_we,
    input  logic [C_DET_W-1:0] i_cfg_wdata
);

    t_recip  recip;
    t_step   step;
    t_wts    wts;
    t_coord  r_coords [C_N_COORDS];
    t_coord  pt_x, pt_y;
    logic    en, accept, w_busy, b_busy, out_valid;

    assign en         = !out_valid || i_m_tready;
    assign o_s_tready = !recip.busy && !i_cfg_we && !step.valid && !w_busy && !b_busy;
    assign accept     = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int k = 0; k < C_N_COORDS; k++) begin
                r_coords[k] <= i_s_tdata[C_COORD_W*k +: C_COORD_W];
            end
        end
    end

    cbt_recip u_recip (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_recip     (recip)
    );

    cbt_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_en    (en),
        .i_recip (recip),
        .o_step  (step)
    );

    cbt_weights u_weights (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_step  (step),
        .o_wts   (wts),
        .o_busy  (w_busy)
    );

    cbt_blend u_blend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_wts    (wts),
        .i_coords (r_coords),
        .o_x      (pt_x),
        .o_y      (pt_y),
        .o_last   (o_m_tlast),
        .o_valid  (out_valid),
        .o_busy   (b_busy)
    );

    assign o_m_tvalid = out_valid;
    assign o_m_tdata  = {pt_y, pt_x};

endmodule
